[hw/rtl/bpa_pkg.sv]
// Shared types and constants of the bitmap page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int WordBits = 64;
  localparam int BitIdxW  = 6;
  localparam int AddrW    = 28;
  localparam int CfgW     = 17;
  localparam int CfgIdxW  = 4;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK  = 2'd0,
    STS_OOM = 2'd1,
    STS_BAD = 2'd2,
    STS_RSV = 2'd3
  } status_e;

  localparam logic [CfgIdxW-1:0] CfgTotal = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFirst = CfgIdxW'(1);

  localparam logic [CfgW-1:0] TotalReset = CfgW'(65536);
  localparam logic [CfgW-1:0] FirstReset = CfgW'(1538);
  localparam logic [CfgW-1:0] CountMax   = {CfgW{1'b1}};

endpackage

[hw/rtl/bpa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/bitmap_page_allocator.sv]
// Bitmap page frame allocator, first fit, one used bit per page in a word RAM.
//
// Input channel (in_valid_i / in_stall_o) carries operation_i and page_address_i;
// output channel (out_valid_o / out_stall_i) returns status_o, allocated_address_o
// and free_count_o, one result per item. The config port (cfg_valid_i /
// cfg_ready_o) writes total_page_count (index 0) and first_usable_page (index 1).
// One item at a time; in_stall_o is high from acceptance until its result is taken.
// Steps of each operation, using the map RAM and the one 64-bit find-first-free unit:
//   initialize: clear sweep over the map, one word a cycle, then the result
//   allocate:   scan of the usable range, one map word examined per cycle
//   free:       read the word, then test and clear the bit; outside the range, straight to the result
//   other:      straight to the result
// After reset the map is cleared by a sweep over all MAP_WORDS words (1024 at the
// default size) during which no item is accepted; config writes are always taken.
// A stalled result holds on the output ports until the receiver takes it.
`timescale 1ns / 1ps

module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES  = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [AddrW-1:0]   page_address_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [AddrW-1:0]   allocated_address_o,
  output logic [CfgW-1:0]    free_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int MapWords  = (MAX_PAGES + WordBits - 1) / WordBits;
  localparam int AW        = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int EWRaw     = $clog2(MAX_PAGES + 1);
  localparam int EW        = (EWRaw > CfgW) ? EWRaw : CfgW;
  localparam int PageShift = $clog2(PAGE_BYTES);
  localparam int FPW       = AddrW - PageShift;
  localparam int CW        = (EW > FPW) ? EW : FPW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_CHK,
    ST_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [CfgW-1:0]     total_q, total_d;
  logic [CfgW-1:0]     first_q, first_d;
  logic [CfgW-1:0]     cnt_q, cnt_d;
  logic                init_q, init_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [AW-1:0]       scan_addr_q, scan_addr_d;
  logic                scan_last_q, scan_last_d;
  logic [AW-1:0]       chk_addr_q, chk_addr_d;
  logic                chk_vld_q, chk_vld_d;
  logic [AW-1:0]       free_word_q, free_word_d;
  logic [BitIdxW-1:0]  free_bit_q, free_bit_d;
  logic [1:0]          status_q, status_d;
  logic [AddrW-1:0]    alloc_addr_q, alloc_addr_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WordBits-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WordBits-1:0] ram_rdata;

  // Usable range derived from the config registers.
  logic [EW-1:0]       end_pg, end_m1, first_e;
  logic                range_ok;
  logic [AW-1:0]       first_word, last_word;
  logic [CfgW-1:0]     init_cnt;

  always_comb begin
    end_pg   = (EW'(total_q) < EW'(MAX_PAGES)) ? EW'(total_q) : EW'(MAX_PAGES);
    first_e  = EW'(first_q);
    end_m1   = end_pg - EW'(1);
    range_ok = end_pg > first_e;
    first_word = AW'(first_e >> BitIdxW);
    last_word  = AW'(end_m1 >> BitIdxW);
    init_cnt   = range_ok ? CfgW'(end_pg - first_e) : '0;
  end

  // Find-first-free unit over one map word.
  logic [BitIdxW-1:0]  word_lo, word_hi, bit_idx;
  logic [WordBits-1:0] word_mask, free_vec, first_hot;
  logic                found;
  logic [EW-1:0]       found_page;
  logic [EW+PageShift-1:0] found_byte;

  always_comb begin
    word_lo   = (chk_addr_q == first_word) ? first_e[BitIdxW-1:0] : '0;
    word_hi   = (chk_addr_q == last_word) ? end_m1[BitIdxW-1:0] : {BitIdxW{1'b1}};
    word_mask = ({WordBits{1'b1}} << word_lo)
              & ({WordBits{1'b1}} >> ({BitIdxW{1'b1}} - word_hi));
    free_vec  = ~ram_rdata & word_mask;
    first_hot = free_vec & (~free_vec + WordBits'(1));
    found     = |free_vec;
    bit_idx   = '0;
    for (int b = 0; b < WordBits; b++) begin
      bit_idx = bit_idx | (first_hot[b] ? BitIdxW'(b) : '0);
    end
    found_page = (EW'(chk_addr_q) << BitIdxW) | EW'(bit_idx);
    found_byte = {found_page, {PageShift{1'b0}}};
  end

  // Free address decode.
  logic [FPW-1:0] in_page;
  logic           in_page_ok;

  always_comb begin
    in_page    = page_address_i[AddrW-1:PageShift];
    in_page_ok = (CW'(in_page) >= CW'(first_q)) && (CW'(in_page) < CW'(end_pg));
  end

  logic in_acc;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    first_d      = first_q;
    cnt_d        = cnt_q;
    init_d       = init_q;
    clr_d        = clr_q;
    scan_addr_d  = scan_addr_q;
    scan_last_d  = scan_last_q;
    chk_addr_d   = chk_addr_q;
    chk_vld_d    = chk_vld_q;
    free_word_d  = free_word_q;
    free_bit_d   = free_bit_q;
    status_d     = status_q;
    alloc_addr_d = alloc_addr_q;
    ram_we       = 1'b0;
    ram_waddr    = clr_q;
    ram_wdata    = '0;
    ram_raddr    = scan_addr_q;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgTotal: total_d = cfg_data_i;
        CfgFirst: first_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(MapWords - 1)) begin
          clr_d = '0;
          if (init_q) begin
            cnt_d        = init_cnt;
            status_d     = STS_OK;
            alloc_addr_d = '0;
            init_d       = 1'b0;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        ram_raddr = AW'(in_page >> BitIdxW);
        if (in_acc) begin
          status_d     = STS_OK;
          alloc_addr_d = '0;
          case (op_e'(operation_i))
            OP_INIT: begin
              init_d  = 1'b1;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_ALLOC: begin
              if (range_ok) begin
                scan_addr_d = first_word;
                scan_last_d = 1'b0;
                chk_vld_d   = 1'b0;
                state_d     = ST_SCAN;
              end else begin
                status_d = STS_OOM;
                state_d  = ST_RESP;
              end
            end
            OP_FREE: begin
              free_word_d = AW'(in_page >> BitIdxW);
              free_bit_d  = in_page[BitIdxW-1:0];
              if (in_page_ok) begin
                state_d = ST_FREE_CHK;
              end else begin
                status_d = STS_BAD;
                state_d  = ST_RESP;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        // issue the next word while testing the one that just came back
        chk_vld_d  = !scan_last_q;
        chk_addr_d = scan_addr_q;
        if (!scan_last_q) begin
          scan_addr_d = scan_addr_q + AW'(1);
          scan_last_d = (scan_addr_q == last_word);
        end
        if (chk_vld_q) begin
          if (found) begin
            ram_we       = 1'b1;
            ram_waddr    = chk_addr_q;
            ram_wdata    = ram_rdata | first_hot;
            cnt_d        = (cnt_q != '0) ? cnt_q - CfgW'(1) : cnt_q;
            alloc_addr_d = AddrW'(found_byte);
            status_d     = STS_OK;
            state_d      = ST_RESP;
          end else if (chk_addr_q == last_word) begin
            status_d = STS_OOM;
            state_d  = ST_RESP;
          end
        end
      end
      ST_FREE_CHK: begin
        if (ram_rdata[free_bit_q]) begin
          ram_we    = 1'b1;
          ram_waddr = free_word_q;
          ram_wdata = ram_rdata & ~(WordBits'(1) << free_bit_q);
          cnt_d     = (cnt_q != CountMax) ? cnt_q + CfgW'(1) : cnt_q;
          status_d  = STS_OK;
        end else begin
          status_d = STS_BAD;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      total_q     <= TotalReset;
      first_q     <= FirstReset;
      cnt_q       <= '0;
      init_q      <= 1'b0;
      clr_q       <= '0;
      scan_last_q <= 1'b0;
      chk_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      first_q     <= first_d;
      cnt_q       <= cnt_d;
      init_q      <= init_d;
      clr_q       <= clr_d;
      scan_last_q <= scan_last_d;
      chk_vld_q   <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q  <= scan_addr_d;
    chk_addr_q   <= chk_addr_d;
    free_word_q  <= free_word_d;
    free_bit_q   <= free_bit_d;
    status_q     <= status_d;
    alloc_addr_q <= alloc_addr_d;
  end

  bpa_ram #(
    .WIDTH (WordBits),
    .DEPTH (MapWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o         = (state_q == ST_RESP);
  assign status_o            = status_q;
  assign allocated_address_o = alloc_addr_q;
  assign free_count_o        = cnt_q;

  // The map is never written while waiting for an item or holding a result.
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_RESP) |-> !ram_we)
    else $error("map written outside an operation");

  // An accepted item always makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block not busy after accepting an item");

  // An out-of-memory result never carries an address.
  a_oom_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STS_OOM) |-> (allocated_address_o == '0))
    else $error("address reported with out of memory");

  // The scan never tests a word past the end of the usable range.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && chk_vld_q) |-> (chk_addr_q <= last_word))
    else $error("scan ran past the last usable word");

  // The free count only moves when an operation finishes.
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_RESP) |=> $stable(cnt_q))
    else $error("free count changed while no operation was running");

endmodule

[tb/bpa_checker.sv]
// Checker for the bitmap page allocator: tracks the page map and compares every result.
`timescale 1ns / 1ps

module bpa_checker
  import bpa_pkg::*;
#(
  parameter int MaxPages  = 65536,
  parameter int PageBytes = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         operation_i,
  input  logic [AddrW-1:0]   page_address_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [AddrW-1:0]   allocated_address_i,
  input  logic [CfgW-1:0]    free_count_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 result_count_o,
  output int                 oom_count_o,
  output int                 bad_count_o
);

  localparam int MapWords = (MaxPages + WordBits - 1) / WordBits;

  typedef struct packed {
    status_e           status;
    logic [AddrW-1:0]  addr;
    logic [CfgW-1:0]   count;
  } alloc_result_t;

  logic [WordBits-1:0] used_map [MapWords];
  logic [CfgW-1:0]     model_free_cnt;
  logic [CfgW-1:0]     model_total;
  logic [CfgW-1:0]     first_page;
  alloc_result_t       expected_q [$];
  alloc_result_t       want;
  int                  fails;
  int                  n_results;
  int                  n_oom;
  int                  n_bad;

  assign fail_count_o   = fails;
  assign pending_o      = expected_q.size();
  assign result_count_o = n_results;
  assign oom_count_o    = n_oom;
  assign bad_count_o    = n_bad;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (fails < 40) begin
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, exp_val);
    end
    fails++;
  endtask

  // Apply one item to the model map and return the result it should produce.
  task automatic predict_item(input logic [1:0] op, input logic [AddrW-1:0] addr,
                              output alloc_result_t res);
    int   end_pg;
    int   lo;
    int   p;
    int   w;
    int   page;
    logic found;
    end_pg = (int'(model_total) < MaxPages) ? int'(model_total) : MaxPages;
    lo = int'(first_page);
    res.status = STS_OK;
    res.addr = '0;
    case (op_e'(op))
      OP_INIT: begin
        for (w = 0; w < MapWords; w++) used_map[w] = '0;
        model_free_cnt = (end_pg > lo) ? CfgW'(end_pg - lo) : '0;
      end
      OP_ALLOC: begin
        res.status = STS_OOM;
        found = 1'b0;
        p = lo;
        while (p < end_pg && !found) begin
          if ((p % WordBits) == 0 && (&used_map[p / WordBits])) begin
            // skip a word that is full
            p += WordBits;
          end else if (!used_map[p / WordBits][p % WordBits]) begin
            used_map[p / WordBits][p % WordBits] = 1'b1;
            if (model_free_cnt != '0) model_free_cnt = model_free_cnt - 1'b1;
            res.addr = AddrW'(longint'(p) * PageBytes);
            res.status = STS_OK;
            found = 1'b1;
          end else begin
            p++;
          end
        end
      end
      OP_FREE: begin
        page = int'(addr) / PageBytes;
        if (page < lo || page >= end_pg || !used_map[page / WordBits][page % WordBits]) begin
          res.status = STS_BAD;
        end else begin
          used_map[page / WordBits][page % WordBits] = 1'b0;
          if (model_free_cnt != CountMax) model_free_cnt = model_free_cnt + 1'b1;
        end
      end
      default: ;
    endcase
    res.count = model_free_cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MapWords; w++) used_map[w] = '0;
      model_free_cnt = '0;
      model_total    = TotalReset;
      first_page     = FirstReset;
      expected_q.delete();
      fails = 0;
      n_results = 0;
      n_oom = 0;
      n_bad = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgTotal: model_total = cfg_data_i;
          CfgFirst: first_page = cfg_data_i;
          default: ;
        endcase
      end
      // compare before predicting: a result always belongs to an older item
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no item outstanding", 32'(status_i), 32'(0));
        end else begin
          want = expected_q.pop_front();
          n_results++;
          if (want.status == STS_OOM) n_oom++;
          if (want.status == STS_BAD) n_bad++;
          if (status_i !== want.status) begin
            report_mismatch("status", 32'(status_i), 32'(want.status));
          end
          if (allocated_address_i !== want.addr) begin
            report_mismatch("allocated_address", 32'(allocated_address_i), 32'(want.addr));
          end
          if (free_count_i !== want.count) begin
            report_mismatch("free_count", 32'(free_count_i), 32'(want.count));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_item(operation_i, page_address_i, want);
        expected_q.push_back(want);
      end
    end
  end

endmodule

[tb/tb.sv]
// Testbench top for the bitmap page allocator: stimulus, reset, timeout and verdict.
`timescale 1ns / 1ps

module tb;
  import bpa_pkg::*;

  localparam int MaxPages    = 65536;
  localparam int PageBytes   = 4096;
  localparam int MapWords    = (MaxPages + WordBits - 1) / WordBits;
  localparam int RandomItems = 530;
  localparam int CycleLimit  = 5_000_000;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i = OP_NONE;
  logic [AddrW-1:0]   page_address_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [AddrW-1:0]   allocated_address_o;
  logic [CfgW-1:0]    free_count_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgTotal;
  logic [CfgW-1:0]    cfg_data_i = '0;

  int fail_count;
  int pending;
  int result_count;
  int oom_count;
  int bad_count;

  bit calm = 1'b0;
  int cycle_count = 0;
  int n_sent = 0;
  int n_settings = 0;
  int cur_total = 65536;
  int cur_first = 1538;

  bitmap_page_allocator #(
    .MAX_PAGES (MaxPages),
    .PAGE_BYTES(PageBytes)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .page_address_i     (page_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .allocated_address_o(allocated_address_o),
    .free_count_o       (free_count_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  bpa_checker #(
    .MaxPages (MaxPages),
    .PageBytes(PageBytes)
  ) alloc_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .operation_i        (operation_i),
    .page_address_i     (page_address_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_i           (status_o),
    .allocated_address_i(allocated_address_o),
    .free_count_i       (free_count_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .result_count_o     (result_count),
    .oom_count_o        (oom_count),
    .bad_count_o        (bad_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver stalls at random, except during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99, 0) < 20);
  end

  function automatic logic [AddrW-1:0] page_addr(input int page, input int offset);
    return AddrW'(longint'(page) * PageBytes + offset);
  endfunction

  task automatic send_item(input op_e op, input logic [AddrW-1:0] addr);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99, 0) < 20) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    page_address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  // Drop valid and hold until every outstanding item has its result.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgW'(data);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_range(input bit do_total, input int total, input bit do_first,
                           input int first);
    wait_idle();
    if (do_total) begin
      write_reg(CfgTotal, total);
      cur_total = total;
    end
    if (do_first) begin
      write_reg(CfgFirst, first);
      cur_first = first;
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int base;
    int phase;
    int n_items;
    int allocs;
    int r;
    int total;
    int first;
    int page;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: allocate and free before initialize, on the reset range.
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, page_addr(1538, 4095));
    send_item(OP_FREE, page_addr(1538, 0));
    send_item(OP_INIT, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, '0);
    send_item(OP_FREE, {AddrW{1'b1}});
    send_item(OP_NONE, {AddrW{1'b1}});
    send_item(OP_ALLOC, '0);
    // shrink the range without initialize: map and count carry over
    set_range(1'b1, 70, 1'b1, 67);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, page_addr(1538, 0));
    send_item(OP_INIT, '0);
    repeat (4) send_item(OP_ALLOC, '0);
    send_item(OP_FREE, page_addr(68, 123));
    send_item(OP_ALLOC, '0);
    // first usable at the end: empty range
    set_range(1'b0, 0, 1'b1, 70);
    send_item(OP_INIT, '0);
    send_item(OP_ALLOC, '0);
    set_range(1'b1, 0, 1'b1, 0);
    send_item(OP_INIT, '0);
    set_range(1'b1, MaxPages, 1'b1, 0);
    send_item(OP_INIT, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, '0);
    set_range(1'b0, 0, 1'b1, MaxPages);
    send_item(OP_INIT, '0);
    send_item(OP_ALLOC, '0);

    base = n_sent;
    phase = 0;
    while (n_sent < base + RandomItems) begin
      case ($urandom_range(9, 0))
        0: begin
          total = MaxPages;
          first = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(2047, 0);
        end
        1: begin
          total = $urandom_range(64, 0);
          first = total + $urandom_range(3, 0);
        end
        2: begin
          total = $urandom_range(MaxPages, 1024);
          first = total - $urandom_range(300, 0);
        end
        default: begin
          total = $urandom_range(700, 1);
          first = $urandom_range(total / 2, 0);
        end
      endcase
      set_range(1'b1, total, 1'b1, first);
      calm = (phase >= 6 && phase <= 9);
      send_item(OP_INIT, '0);
      allocs = 0;
      n_items = $urandom_range(40, 15);
      repeat (n_items) begin
        r = $urandom_range(99, 0);
        if (r < 45) begin
          send_item(OP_ALLOC, '0);
          allocs++;
        end else if (r < 80) begin
          // free a page that first fit has likely handed out
          page = cur_first + $urandom_range(allocs + 1, 0);
          send_item(OP_FREE, page_addr(page, $urandom_range(PageBytes - 1, 0)));
        end else if (r < 88) begin
          send_item(OP_FREE, AddrW'($urandom));
        end else if (r < 92) begin
          send_item(OP_NONE, AddrW'($urandom));
        end else if (r < 95) begin
          send_item(OP_INIT, '0);
          allocs = 0;
        end else if (r < 98) begin
          first = $urandom_range(cur_first + 8, 0);
          if (first > MaxPages) first = MaxPages;
          set_range(1'b0, 0, 1'b1, first);
        end else begin
          total = $urandom_range(cur_total + 16, 0);
          if (total > MaxPages) total = MaxPages;
          set_range(1'b1, total, 1'b0, 0);
        end
      end
      phase++;
    end
    calm = 1'b0;

    wait_idle();
    repeat (MapWords + 8) @(posedge clk_i);

    $display("Sent %0d items over %0d register settings in %0d cycles.",
             n_sent, n_settings, cycle_count);
    $display("Checked %0d results: %0d out of memory, %0d rejected frees.",
             result_count, oom_count, bad_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
